/* hdl/crcr_pkg.sv */
// ============================================================================
// crcr_pkg: shared types, constants and the single-bit CRC step
// Widths of the remainder path, configuration codes and the GF(2) shift
// function used by both the word stage and the flush engine.
// ============================================================================
package crcr_pkg;

    localparam int REM_W          = 31;  // widest remainder held by the datapath
    localparam int IDX_W          = $clog2(REM_W);
    localparam int DEG_W          = 5;   // width of the degree register
    localparam int CFG_W          = 32;  // configuration write data width
    localparam int CFG_IDX_W      = 1;
    localparam int NIB_W          = 4;
    localparam int FLUSH_STEP     = 4;   // zero bits flushed per cycle
    localparam int QUEUE_DEPTH    = 2;
    localparam int CRC_MAX_DEGREE = 31;
    localparam int GEN_RESET      = 32'h0001_1021;
    localparam int DEG_RESET      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE    = 1'b1;

    // Live configuration as seen by the datapath; deg is already saturated.
    typedef struct packed {
        logic [REM_W-1:0] gen;
        logic [DEG_W-1:0] deg;
    } t_cfg;

    // One bit of polynomial division: shift left, take the new bit, and
    // reduce by the generator when the bit leaving the top was set.
    function automatic logic [REM_W-1:0] f_crc_shift(
        input logic [REM_W-1:0] crc,
        input logic             din,
        input t_cfg             cfg
    );
        logic [REM_W-1:0] mask;
        logic             top;
        logic [REM_W-1:0] nxt;
        mask = ~({REM_W{1'b1}} << cfg.deg);
        top  = (cfg.deg != '0) ? crc[IDX_W'(cfg.deg - 1'b1)] : 1'b0;
        nxt  = {crc[REM_W-2:0], din} & mask;
        if (top) begin
            nxt = nxt ^ (cfg.gen & mask);
        end
        return nxt;
    endfunction

endpackage

/* hdl/crcr_front.sv */
// ============================================================================
// crcr_front: word stage of the CRC engine
// Folds four message bits per accepted word into the running remainder and
// hands the remainder of a finished frame to the flush queue.
// ============================================================================
module crcr_front #(
    parameter int MAX_DEGREE = crcr_pkg::CRC_MAX_DEGREE
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  crcr_pkg::t_cfg            i_cfg,
    input  logic                      i_valid,
    input  logic [crcr_pkg::NIB_W-1:0] i_nibble,
    input  logic                      i_last,
    input  logic                      i_q_full,
    output logic                      o_stall,
    output logic                      o_push,
    output logic [((MAX_DEGREE < crcr_pkg::REM_W) ? MAX_DEGREE : crcr_pkg::REM_W)-1:0]
                                      o_push_data
);
    import crcr_pkg::*;

    localparam int REG_W = (MAX_DEGREE < REM_W) ? MAX_DEGREE : REM_W;

    logic [REG_W-1:0] r_crc;
    logic [REM_W-1:0] n_crc;
    logic             accept;

    // Four dependent shift steps, most significant message bit first.
    always_comb begin
        n_crc = REM_W'(r_crc);
        for (int i = 0; i < NIB_W; i++) begin
            n_crc = f_crc_shift(n_crc, i_nibble[2'(NIB_W - 1 - i)], i_cfg);
        end
    end

    assign o_stall     = i_q_full;
    assign accept      = i_valid && !o_stall;
    assign o_push      = accept && i_last;
    assign o_push_data = REG_W'(n_crc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= '0;
        end else if (accept) begin
            r_crc <= i_last ? '0 : REG_W'(n_crc);
        end
    end

endmodule

/* hdl/crcr_queue.sv */
// ============================================================================
// crcr_queue: small first-in first-out buffer
// Holds frame remainders between the word stage and the flush engine.
// ============================================================================
module crcr_queue #(
    parameter int WIDTH = crcr_pkg::REM_W,
    parameter int DEPTH = crcr_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hdl/crcr_back.sv */
// ============================================================================
// crcr_back: flush engine and result register
// Shifts degree zero bits through each queued remainder, four per cycle,
// and presents the finished remainder in an output register.
// ============================================================================
module crcr_back #(
    parameter int MAX_DEGREE = crcr_pkg::CRC_MAX_DEGREE
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  crcr_pkg::t_cfg             i_cfg,
    input  logic                       i_q_valid,
    input  logic [((MAX_DEGREE < crcr_pkg::REM_W) ? MAX_DEGREE : crcr_pkg::REM_W)-1:0]
                                       i_q_data,
    output logic                       o_q_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [crcr_pkg::REM_W-1:0] o_remainder
);
    import crcr_pkg::*;

    localparam int REG_W = (MAX_DEGREE < REM_W) ? MAX_DEGREE : REM_W;

    logic             r_busy;
    logic [DEG_W-1:0] r_cnt;
    logic [REG_W-1:0] r_work;
    logic             r_out_valid;
    logic [REM_W-1:0] r_rem;

    logic [REM_W-1:0] n_work;
    logic [DEG_W-1:0] n_cnt;
    logic             done;
    logic             move;

    // Up to four zero bits this cycle; fewer on the final step of a flush.
    always_comb begin
        n_work = REM_W'(r_work);
        for (int j = 0; j < FLUSH_STEP; j++) begin
            if (DEG_W'(j) < r_cnt) begin
                n_work = f_crc_shift(n_work, 1'b0, i_cfg);
            end
        end
        n_cnt = (r_cnt > DEG_W'(FLUSH_STEP)) ? r_cnt - DEG_W'(FLUSH_STEP) : '0;
    end

    assign done        = r_busy && (r_cnt == '0);
    assign move        = done && (!r_out_valid || !i_stall);
    assign o_q_pop     = i_q_valid && (!r_busy || move);
    assign o_valid     = r_out_valid;
    assign o_remainder = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (move) begin
                r_out_valid <= 1'b1;
                r_rem       <= REM_W'(r_work);
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_work <= i_q_data;
                r_cnt  <= i_cfg.deg;
            end else if (move) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_work <= REG_W'(n_work);
                r_cnt  <= n_cnt;
            end
        end
    end

endmodule

/* hdl/crc_remainder_generic.sv */
// ============================================================================
// crc_remainder_generic: streaming CRC remainder generator
// Polynomial division over GF(2) with a programmable generator and degree,
// fed four message bits per word, emitting one remainder per frame.
// ============================================================================
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  ---------------------------
//  in        sink       i_in_valid / o_in_stall    i_nibble, i_last
//  out       source     o_out_valid / i_out_stall  o_remainder
//  cfg       sink       i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// The word stage takes one input word every cycle while the two-entry frame
// queue has room; its four chained shift steps set that figure.
// Each frame is then flushed four zero bits per step and moved into the
// result register, and the next queued frame is loaded in that same move
// cycle, so frames with more words than flush steps stream at one word per
// cycle while results are taken; shorter frames back up in the queue.
// Reset is synchronous and active low; it clears the running remainder, the
// queue and all valid flags, and restores the generator and degree.
// A stalled result waits in the output register while further words are
// still accepted until the queue fills; o_in_stall depends on queue fill
// only.
//
module crc_remainder_generic #(
    parameter int MAX_DEGREE = crcr_pkg::CRC_MAX_DEGREE
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input words
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [crcr_pkg::NIB_W-1:0]     i_nibble,
    input  logic                           i_last,
    // Results
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [crcr_pkg::REM_W-1:0]     o_remainder,
    // Configuration writes
    input  logic                           i_cfg_we,
    input  logic [crcr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [crcr_pkg::CFG_W-1:0]     i_cfg_data
);
    import crcr_pkg::*;

    localparam int REG_W = (MAX_DEGREE < REM_W) ? MAX_DEGREE : REM_W;

    // Only the low bits of the generator can ever reach the datapath, as
    // the mask never extends past bit thirty.
    logic [REM_W-1:0] r_gen;
    logic [DEG_W-1:0] r_degree;
    t_cfg             cfg;

    logic             q_push;
    logic [REG_W-1:0] q_push_data;
    logic             q_pop;
    logic             q_valid;
    logic             q_full;
    logic [REG_W-1:0] q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen    <= REM_W'(GEN_RESET);
            r_degree <= DEG_W'(DEG_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GENERATOR: r_gen    <= REM_W'(i_cfg_data);
                CFG_DEGREE:    r_degree <= DEG_W'(i_cfg_data);
                default:       r_gen    <= r_gen;
            endcase
        end
    end

    // A degree beyond what the datapath holds saturates to its maximum.
    always_comb begin
        cfg.gen = r_gen;
        cfg.deg = (32'(r_degree) > 32'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : r_degree;
    end

    crcr_front #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_in_valid),
        .i_nibble    (i_nibble),
        .i_last      (i_last),
        .i_q_full    (q_full),
        .o_stall     (o_in_stall),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    crcr_queue #(
        .WIDTH (REG_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_push_data),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_data)
    );

    crcr_back #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_remainder (o_remainder)
    );

endmodule

/* hdl/crcr_chk.sv */
// ============================================================================
// crcr_chk: port-level checks for the CRC remainder generator
// Watches handshakes, frame accounting and remainder width at the ports.
// ============================================================================
module crcr_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           i_last,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [crcr_pkg::REM_W-1:0]     o_remainder,
    input logic                           i_cfg_we,
    input logic [crcr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [crcr_pkg::CFG_W-1:0]     i_cfg_data
);
    import crcr_pkg::*;

    logic [3:0]       r_pending;
    logic [DEG_W-1:0] r_deg;
    logic             last_in;
    logic             res_out;

    assign last_in = i_in_valid && !o_in_stall && i_last;
    assign res_out = o_out_valid && !i_out_stall;

    // Frames closed at the input whose results have not yet left.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_deg     <= DEG_W'(DEG_RESET);
        end else begin
            if (last_in && !res_out) begin
                r_pending <= r_pending + 1'b1;
            end else if (!last_in && res_out) begin
                r_pending <= r_pending - 1'b1;
            end
            if (i_cfg_we && (i_cfg_index == CFG_DEGREE)) begin
                r_deg <= DEG_W'(i_cfg_data);
            end
        end
    end

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result withdrawn while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_remainder))
        else $error("stalled remainder changed");

    a_result_has_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pending != '0))
        else $error("result without a closed frame");

    a_remainder_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_remainder >> r_deg) == '0))
        else $error("remainder bits set at or above the degree");

endmodule

bind crc_remainder_generic crcr_chk u_crcr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_last      (i_last),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_remainder (o_remainder),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

/* verif/tb.sv */
// ============================================================================
// tb: self-checking testbench for crc_remainder_generic
// Streams message words through the CRC engine under several generator and
// degree settings and checks every emitted remainder against a bit-serial
// polynomial division computed alongside or against a remainder typed into
// the directed table. Idling and stalls on both channels are randomised.
// ============================================================================
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import crcr_pkg::*;

    // Number of random message words after the directed table.
    localparam int RANDOM_WORDS = 800;
    // Cycles allowed for a frame to leave the flush engine and the result
    // register once the last expected remainder has been seen.
    localparam int DRAIN_CYCLES = 16;
    // Cycles in a row with no handshake on any port before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } t_row_kind;

    // One row of the directed table: either a message word, optionally with
    // a remainder typed in by hand, or a register write.
    typedef struct packed {
        t_row_kind              kind;
        logic [NIB_W-1:0]       nib;
        logic                   lst;
        logic                   typed;
        logic [REM_W-1:0]       rem;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       data;
    } t_dir_row;

    localparam int DIR_ROWS = 28;

    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // Reset settings: a frame of zeros leaves a zero remainder.
        '{ROW_WORD, 4'h0, 1'b1, 1'b1, 31'd0, CFG_GENERATOR, 32'd0},
        '{ROW_WORD, 4'hF, 1'b1, 1'b0, 31'd0, CFG_GENERATOR, 32'd0},
        '{ROW_WORD, 4'h3, 1'b0, 1'b0, 31'd0, CFG_GENERATOR, 32'd0},
        '{ROW_WORD, 4'h9, 1'b1, 1'b0, 31'd0, CFG_GENERATOR, 32'd0},
        // x + 1 of degree one: the remainder is the parity of the message.
        '{ROW_CFG,  4'h0, 1'b0, 1'b0, 31'd0, CFG_GENERATOR, 32'h0000_0003},
        '{ROW_CFG,  4'h0, 1'b0, 1'b0, 31'd0, CFG_DEGREE,    32'd1},
        '{ROW_WORD, 4'h1, 1'b1, 1'b1, 31'd1, CFG_GENERATOR, 32'd0},
        '{ROW_WORD, 4'hF, 1'b1, 1'b1, 31'd0, CFG_GENERATOR, 32'd0},
        // Degree zero: nothing is held and every remainder is zero.
        '{ROW_CFG,  4'h0, 1'b0, 1'b0, 31'd0, CFG_DEGREE,    32'd0},
        '{ROW_WORD, 4'hA, 1'b1, 1'b1, 31'd0, CFG_GENERATOR, 32'd0},
        '{ROW_WORD, 4'h5, 1'b0, 1'b0, 31'd0, CFG_GENERATOR, 32'd0},
        '{ROW_WORD, 4'hF, 1'b1, 1'b1, 31'd0, CFG_GENERATOR, 32'd0},
        // Widest remainder with an all-ones generator; the degree write
        // carries ones in every unused data bit as well.
        '{ROW_CFG,  4'h0, 1'b0, 1'b0, 31'd0, CFG_GENERATOR, 32'hFFFF_FFFF},
        '{ROW_CFG,  4'h0, 1'b0, 1'b0, 31'd0, CFG_DEGREE,    32'hFFFF_FFFF},
        '{ROW_WORD, 4'hF, 1'b0, 1'b0, 31'd0, CFG_GENERATOR, 32'd0},
        '{ROW_WORD, 4'hF, 1'b0, 1'b0, 31'd0, CFG_GENERATOR, 32'd0},
        '{ROW_WORD, 4'hF, 1'b1, 1'b0, 31'd0, CFG_GENERATOR, 32'd0},
        // Settings changed in the middle of a frame apply to the rest of it.
        '{ROW_WORD, 4'h5, 1'b0, 1'b0, 31'd0, CFG_GENERATOR, 32'd0},
        '{ROW_CFG,  4'h0, 1'b0, 1'b0, 31'd0, CFG_GENERATOR, 32'h0000_0107},
        '{ROW_CFG,  4'h0, 1'b0, 1'b0, 31'd0, CFG_DEGREE,    32'd8},
        '{ROW_WORD, 4'hC, 1'b1, 1'b0, 31'd0, CFG_GENERATOR, 32'd0},
        // Generator bits at and above the degree are ignored, so a missing
        // leading one and junk above it make no difference.
        '{ROW_CFG,  4'h0, 1'b0, 1'b0, 31'd0, CFG_DEGREE,    32'd16},
        '{ROW_CFG,  4'h0, 1'b0, 1'b0, 31'd0, CFG_GENERATOR, 32'hFFFE_1021},
        '{ROW_WORD, 4'h6, 1'b0, 1'b0, 31'd0, CFG_GENERATOR, 32'd0},
        '{ROW_WORD, 4'hC, 1'b1, 1'b0, 31'd0, CFG_GENERATOR, 32'd0},
        // A zero generator never reduces: the flush shifts the whole message
        // out and the remainder is zero.
        '{ROW_CFG,  4'h0, 1'b0, 1'b0, 31'd0, CFG_GENERATOR, 32'd0},
        '{ROW_WORD, 4'h7, 1'b0, 1'b0, 31'd0, CFG_GENERATOR, 32'd0},
        '{ROW_WORD, 4'h0, 1'b1, 1'b0, 31'd0, CFG_GENERATOR, 32'd0}
    };

    // Clock, reset and the block's inputs, all known from time zero.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [NIB_W-1:0]     i_nibble    = '0;
    logic                 i_last      = 1'b0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [REM_W-1:0]     o_remainder;

    // Our own view of the engine: the settings as last written and the
    // running remainder of the frame in progress.
    logic [CFG_W-1:0]     gen_setting;
    logic [DEG_W-1:0]     deg_setting;
    logic [31:0]          crc_running;

    // Remainders owed by the block, oldest first.
    logic [REM_W-1:0]     remainders_due [$];

    int n_errors   = 0;
    int n_words    = 0;
    int n_results  = 0;
    int n_settings = 0;
    int idle_cycles = 0;

    // Chance, in percent, that the sender holds back a word or the receiver
    // stalls in a given cycle.
    int send_idle_pct = 7;
    int recv_idle_pct = 54;

    crc_remainder_generic u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_nibble    (i_nibble),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_remainder (o_remainder),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 20 ns period: ten high, ten low.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // One step of GF(2) long division: shift the next message bit in at the
    // bottom and subtract the generator whenever a one falls off the top.
    // The register is kept to the degree's width, so bits left over from a
    // wider setting vanish at the first shift.
    function automatic logic [31:0] crc_shift_bit(input logic [31:0] crc, input logic din);
        logic [31:0] mask;
        logic        top;
        logic [31:0] nxt;
        if (deg_setting == '0) begin
            return 32'd0;
        end
        mask = 32'hFFFF_FFFF >> (32 - deg_setting);
        top  = crc[deg_setting - 1];
        nxt  = {crc[30:0], din} & mask;
        if (top) begin
            nxt = nxt ^ (gen_setting & mask);
        end
        return nxt;
    endfunction

    // Feed one accepted word through the division. On the last word of a
    // frame the register is flushed with as many zeros as the degree, the
    // remainder is handed back and the register starts afresh.
    task automatic crc_divide_word(input logic [NIB_W-1:0] nib, input logic lst,
                                   output logic [REM_W-1:0] rem);
        rem = '0;
        for (int b = NIB_W - 1; b >= 0; b--) begin
            crc_running = crc_shift_bit(crc_running, nib[b]);
        end
        if (lst) begin
            for (int z = 0; z < int'(deg_setting); z++) begin
                crc_running = crc_shift_bit(crc_running, 1'b0);
            end
            rem         = crc_running[REM_W-1:0];
            crc_running = '0;
        end
    endtask

    // Present one word and hold it until the block takes it. Any idle gap
    // comes first, so valid is only ever assigned once per falling edge and
    // stays high from one word straight into the next.
    task automatic send_word(input logic [NIB_W-1:0] nib, input logic lst,
                             input logic typed, input logic [REM_W-1:0] typed_rem);
        logic [REM_W-1:0] rem;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_nibble   <= nib;
        i_last     <= lst;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        crc_divide_word(nib, lst, rem);
        if (lst) begin
            remainders_due.push_back(typed ? typed_rem : rem);
        end
        n_words++;
    endtask

    // Stop sending and wait until every owed remainder has come out, then
    // give the flush engine time to settle before anything is rewritten.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (remainders_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // A single register write, mirrored into our copy of the settings.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == CFG_GENERATOR) begin
            gen_setting = data;
        end else begin
            deg_setting = data[DEG_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // The receiver stalls at random, re-decided on every falling edge.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Every remainder taken from the block must be the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (remainders_due.size() == 0) begin
                $error("remainder: none expected, got 0x%08h", o_remainder);
                n_errors++;
            end else if (o_remainder !== remainders_due[0]) begin
                $error("remainder: expected 0x%08h, got 0x%08h",
                       remainders_due[0], o_remainder);
                n_errors++;
                void'(remainders_due.pop_front());
            end else begin
                void'(remainders_due.pop_front());
            end
        end
    end

    // A run that goes quiet on every port for too long has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int               random_words;
        int               frame_len;
        int               n_frames;
        int               pick;
        logic [CFG_W-1:0] gen_val;
        logic [DEG_W-1:0] deg_val;
        logic [CFG_W-1:0] deg_data;

        gen_setting  = GEN_RESET;
        deg_setting  = DEG_W'(DEG_RESET);
        crc_running  = '0;
        random_words = 0;

        // Reset is held from time zero, released on a falling edge, and
        // never asserted again.
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Every register write is made with the block idle,
        // which also means the sender waits for all owed remainders.
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                wait_idle();
                write_reg(DIRECTED[r].idx, DIRECTED[r].data);
            end else begin
                send_word(DIRECTED[r].nib, DIRECTED[r].lst, DIRECTED[r].typed,
                          DIRECTED[r].rem);
            end
        end

        // Random frames in blocks, each block under a fresh pair of settings.
        // The idle pattern moves from a slow receiver, to a slow sender, to
        // neither idling, by thirds of the random words.
        while (random_words < RANDOM_WORDS) begin
            pick = $urandom_range(9);
            case (pick)
                0: begin
                    gen_val = $urandom();
                    deg_val = 5'd1;
                end
                1: begin
                    gen_val = $urandom();
                    deg_val = 5'd31;
                end
                2: begin
                    gen_val = '0;
                    deg_val = DEG_W'($urandom_range(31, 1));
                end
                3: begin
                    gen_val = '1;
                    deg_val = DEG_W'($urandom_range(31, 1));
                end
                default: begin
                    gen_val = $urandom();
                    deg_val = DEG_W'($urandom_range(31, 1));
                end
            endcase
            // Unused bits of the degree write carry random junk.
            deg_data = {(CFG_W - DEG_W)'($urandom()), deg_val};
            wait_idle();
            if ($urandom_range(1) == 0) begin
                write_reg(CFG_GENERATOR, gen_val);
                write_reg(CFG_DEGREE, deg_data);
            end else begin
                write_reg(CFG_DEGREE, deg_data);
                write_reg(CFG_GENERATOR, gen_val);
            end

            n_frames = $urandom_range(14, 6);
            for (int f = 0; f < n_frames && random_words < RANDOM_WORDS; f++) begin
                if (random_words < RANDOM_WORDS / 3) begin
                    send_idle_pct = 7;
                    recv_idle_pct = 54;
                end else if (random_words < 2 * RANDOM_WORDS / 3) begin
                    send_idle_pct = 54;
                    recv_idle_pct = 7;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                // Single-word frames keep the flush engine back to back;
                // longer ones let the word stage run ahead of it.
                frame_len = ($urandom_range(9) < 2) ? 1 : $urandom_range(16, 2);
                for (int w = 0; w < frame_len; w++) begin
                    send_word(NIB_W'($urandom()), (w == frame_len - 1), 1'b0, '0);
                    random_words++;
                end
            end
        end

        wait_idle();

        $display("Sent %0d words and checked %0d remainders over %0d register writes,",
                 n_words, n_results, n_settings);
        $display("with degrees from zero to 31 and stalls on either side or neither.");
        if (n_errors == 0 && remainders_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
